FILE: rtl/ole_pkg.sv
// ole_pkg: shared types and constants of the ordered list engine
// holds item codes, status codes, sequencer states and field widths
// no dependencies
package ole_pkg;

    localparam int DEF_CAPACITY = 16;
    localparam int DATA_W       = 32;
    localparam int KIND_W       = 3;
    localparam int POS_W        = 16;
    localparam int STATUS_W     = 2;
    localparam int LEN_W        = 5;

    // operation codes of an input item
    typedef enum logic [KIND_W-1:0] {
        KIND_INS_FRONT = 3'd0,
        KIND_INS_END   = 3'd1,
        KIND_INS_POS   = 3'd2,
        KIND_DEL_FRONT = 3'd3,
        KIND_DEL_END   = 3'd4,
        KIND_DEL_POS   = 3'd5,
        KIND_DUMP      = 3'd6
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_UNDERFLOW = 2'd1,
        STAT_BADPOS    = 2'd2,
        STAT_FULL      = 2'd3
    } t_status;

    // what to do once the link walk reaches its target
    typedef enum logic [1:0] {
        WOP_INSERT,
        WOP_DEL_FRONT,
        WOP_DEL_AFTER
    } t_walk_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_INS2,
        ST_DEL2,
        ST_DUMP,
        ST_RESP
    } t_state;

endpackage

FILE: rtl/ole_store.sv
// ole_store: entry memory of the list, value plus next-slot link per slot
// one write port and one read port, read data registered
// depends on ole_pkg
module ole_store #(
    parameter int CAPACITY = ole_pkg::DEF_CAPACITY
) (
    input  logic                               i_clk,
    input  logic                               i_we,
    input  logic [$clog2(CAPACITY)-1:0]        i_waddr,
    input  logic signed [ole_pkg::DATA_W-1:0]  i_wval,
    input  logic [$clog2(CAPACITY)-1:0]        i_wlink,
    input  logic [$clog2(CAPACITY)-1:0]        i_raddr,
    output logic signed [ole_pkg::DATA_W-1:0]  o_rval,
    output logic [$clog2(CAPACITY)-1:0]        o_rlink
);
    import ole_pkg::*;

    localparam int IW = $clog2(CAPACITY);

    logic signed [DATA_W-1:0] r_val  [CAPACITY];
    logic [IW-1:0]            r_link [CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_val[i_waddr]  <= i_wval;
            r_link[i_waddr] <= i_wlink;
        end
        o_rval  <= r_val[i_raddr];
        o_rlink <= r_link[i_raddr];
    end

endmodule

FILE: rtl/ole_free.sv
// ole_free: free-slot map of the entry memory with lowest-free-slot pick
// a taken slot is cleared, a released slot is set again
// depends on ole_pkg
module ole_free #(
    parameter int CAPACITY = ole_pkg::DEF_CAPACITY
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_take,
    input  logic                        i_give,
    input  logic [$clog2(CAPACITY)-1:0] i_give_slot,
    output logic [$clog2(CAPACITY)-1:0] o_pick
);
    import ole_pkg::*;

    localparam int IW = $clog2(CAPACITY);

    logic [CAPACITY-1:0] r_free;
    logic [CAPACITY-1:0] n_free;

    // lowest free slot
    always_comb begin
        o_pick = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (r_free[i]) begin
                o_pick = IW'(i);
            end
        end
    end

    always_comb begin
        n_free = r_free;
        if (i_take) begin
            n_free[o_pick] = 1'b0;
        end
        if (i_give) begin
            n_free[i_give_slot] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free <= '1;
        end else begin
            r_free <= n_free;
        end
    end

endmodule

FILE: rtl/ordered_list_engine_core.sv
// ordered_list_engine_core: bounded ordered list held as a linked list in one memory
// sequencing: errors, front insert, empty dump need no link walk; positional
// insert/delete at 1-based index k walks the links from the head (one link read per cycle)
// throughput: one item at a time; a dump of n entries gives one result per cycle
// after the head read, as long as the output is not stalled
// reset: synchronous, empties the list and frees all slots; memory is not cleared
module ordered_list_engine_core #(
    parameter int CAPACITY = ole_pkg::DEF_CAPACITY
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input item channel
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [ole_pkg::KIND_W-1:0]         i_kind,
    input  logic signed [ole_pkg::DATA_W-1:0]  i_value,
    input  logic [ole_pkg::POS_W-1:0]          i_position,
    // result item channel
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [ole_pkg::STATUS_W-1:0]       o_status,
    output logic signed [ole_pkg::DATA_W-1:0]  o_element,
    output logic                               o_element_valid,
    output logic                               o_last,
    output logic [ole_pkg::LEN_W-1:0]          o_length
);
    import ole_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = POS_W + 1;

    // sequencer state
    t_state                   r_state, n_state;
    t_walk_op                 r_wop, n_wop;
    t_status                  r_status, n_status;
    logic [IW-1:0]            r_cur, n_cur;      // slot whose data the memory returns
    logic [IW-1:0]            r_steps, n_steps;  // links still to follow
    logic [IW-1:0]            r_prev, n_prev;    // predecessor slot on delete
    logic [IW-1:0]            r_slot, n_slot;    // newly taken slot on insert
    logic [IW-1:0]            r_link, n_link;    // successor link for the new entry
    logic signed [DATA_W-1:0] r_value, n_value;
    logic signed [DATA_W-1:0] r_pval, n_pval;
    logic [IW-1:0]            r_head, n_head;
    logic [CW-1:0]            r_count, n_count;

    // output register
    logic                     r_out_valid, n_out_valid;
    t_status                  r_out_status, n_out_status;
    logic signed [DATA_W-1:0] r_out_el, n_out_el;
    logic                     r_out_ev, n_out_ev;
    logic                     r_out_last, n_out_last;
    logic [LEN_W-1:0]         r_out_len, n_out_len;

    // memory and free map hookup
    logic                     w_we;
    logic [IW-1:0]            w_waddr;
    logic signed [DATA_W-1:0] w_wval;
    logic [IW-1:0]            w_wlink;
    logic signed [DATA_W-1:0] w_rval;
    logic [IW-1:0]            w_rlink;
    logic                     w_take;
    logic                     w_give;
    logic [IW-1:0]            w_give_slot;
    logic [IW-1:0]            w_pick;

    // decode helpers
    logic                     w_accept;
    logic                     w_out_free;
    logic                     w_full;
    logic                     w_empty;
    logic                     w_pos_ins_ok;
    logic                     w_pos_del_ok;
    logic                     w_pos_one;
    logic [IW-1:0]            w_pos_m2;
    logic [IW-1:0]            w_cnt_m1;
    logic [IW-1:0]            w_cnt_m2;
    t_kind                    w_kind;

    ole_store #(.CAPACITY(CAPACITY)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wval  (w_wval),
        .i_wlink (w_wlink),
        .i_raddr (n_cur),
        .o_rval  (w_rval),
        .o_rlink (w_rlink)
    );

    ole_free #(.CAPACITY(CAPACITY)) u_free (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (w_take),
        .i_give      (w_give),
        .i_give_slot (w_give_slot),
        .o_pick      (w_pick)
    );

    assign o_ready    = (r_state == ST_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;
    assign w_kind     = t_kind'(i_kind);

    assign w_full       = (r_count == CW'(CAPACITY));
    assign w_empty      = (r_count == '0);
    assign w_pos_one    = (i_position == POS_W'(1));
    assign w_pos_ins_ok = (i_position != '0) && (PW'(i_position) <= PW'(r_count) + PW'(1));
    assign w_pos_del_ok = (i_position != '0) && (PW'(i_position) <= PW'(r_count));
    // walk lengths: the walk stops on the entry before the target index
    assign w_pos_m2     = IW'(i_position - POS_W'(2));
    assign w_cnt_m1     = IW'(r_count - CW'(1));
    assign w_cnt_m2     = IW'(r_count - CW'(2));

    always_comb begin
        n_state      = r_state;
        n_wop        = r_wop;
        n_status     = r_status;
        n_cur        = r_cur;
        n_steps      = r_steps;
        n_prev       = r_prev;
        n_slot       = r_slot;
        n_link       = r_link;
        n_value      = r_value;
        n_pval       = r_pval;
        n_head       = r_head;
        n_count      = r_count;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_status = r_out_status;
        n_out_el     = r_out_el;
        n_out_ev     = r_out_ev;
        n_out_last   = r_out_last;
        n_out_len    = r_out_len;
        w_we         = 1'b0;
        w_waddr      = r_cur;
        w_wval       = r_value;
        w_wlink      = r_link;
        w_take       = 1'b0;
        w_give       = 1'b0;
        w_give_slot  = r_cur;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    // every walk starts by reading the head entry
                    n_cur    = r_head;
                    n_value  = i_value;
                    n_status = STAT_OK;
                    n_state  = ST_RESP;
                    case (w_kind)
                        KIND_INS_FRONT, KIND_INS_END, KIND_INS_POS: begin
                            if (w_kind == KIND_INS_POS && !w_pos_ins_ok) begin
                                n_status = STAT_BADPOS;
                            end else if (w_full) begin
                                n_status = STAT_FULL;
                            end else if (w_kind == KIND_INS_FRONT
                                         || (w_kind == KIND_INS_END && w_empty)
                                         || (w_kind == KIND_INS_POS && w_pos_one)) begin
                                // new front entry, no walk needed
                                w_we    = 1'b1;
                                w_waddr = w_pick;
                                w_wval  = i_value;
                                w_wlink = r_head;
                                w_take  = 1'b1;
                                n_head  = w_pick;
                                n_count = r_count + CW'(1);
                            end else begin
                                n_wop   = WOP_INSERT;
                                n_steps = (w_kind == KIND_INS_END) ? w_cnt_m1 : w_pos_m2;
                                n_state = ST_WALK;
                            end
                        end
                        KIND_DEL_FRONT, KIND_DEL_END: begin
                            if (w_empty) begin
                                n_status = STAT_UNDERFLOW;
                            end else if (w_kind == KIND_DEL_FRONT
                                         || r_count == CW'(1)) begin
                                n_wop   = WOP_DEL_FRONT;
                                n_steps = '0;
                                n_state = ST_WALK;
                            end else begin
                                n_wop   = WOP_DEL_AFTER;
                                n_steps = w_cnt_m2;
                                n_state = ST_WALK;
                            end
                        end
                        KIND_DEL_POS: begin
                            if (w_pos_one && w_empty) begin
                                n_status = STAT_UNDERFLOW;
                            end else if (!w_pos_del_ok) begin
                                n_status = STAT_BADPOS;
                            end else if (w_pos_one) begin
                                n_wop   = WOP_DEL_FRONT;
                                n_steps = '0;
                                n_state = ST_WALK;
                            end else begin
                                n_wop   = WOP_DEL_AFTER;
                                n_steps = w_pos_m2;
                                n_state = ST_WALK;
                            end
                        end
                        KIND_DUMP: begin
                            // empty list answers with a single empty marker
                            if (!w_empty) begin
                                n_steps = w_cnt_m1;
                                n_state = ST_DUMP;
                            end
                        end
                        default: begin
                            // unused code: no change, plain ok result
                        end
                    endcase
                end
            end

            ST_WALK: begin
                if (r_steps != '0) begin
                    n_cur   = w_rlink;
                    n_steps = r_steps - IW'(1);
                end else begin
                    unique case (r_wop)
                        WOP_INSERT: begin
                            // predecessor now points at the new slot
                            w_we    = 1'b1;
                            w_waddr = r_cur;
                            w_wval  = w_rval;
                            w_wlink = w_pick;
                            w_take  = 1'b1;
                            n_slot  = w_pick;
                            n_link  = w_rlink;
                            n_count = r_count + CW'(1);
                            n_state = ST_INS2;
                        end
                        WOP_DEL_FRONT: begin
                            w_give      = 1'b1;
                            w_give_slot = r_cur;
                            n_head      = w_rlink;
                            n_count     = r_count - CW'(1);
                            n_state     = ST_RESP;
                        end
                        WOP_DEL_AFTER: begin
                            // read the victim to learn its successor
                            n_prev  = r_cur;
                            n_pval  = w_rval;
                            n_cur   = w_rlink;
                            n_state = ST_DEL2;
                        end
                        default: begin
                            n_state = ST_RESP;
                        end
                    endcase
                end
            end

            ST_INS2: begin
                w_we    = 1'b1;
                w_waddr = r_slot;
                w_wval  = r_value;
                w_wlink = r_link;
                n_state = ST_RESP;
            end

            ST_DEL2: begin
                // unlink the victim and release its slot
                w_we        = 1'b1;
                w_waddr     = r_prev;
                w_wval      = r_pval;
                w_wlink     = w_rlink;
                w_give      = 1'b1;
                w_give_slot = r_cur;
                n_count     = r_count - CW'(1);
                n_state     = ST_RESP;
            end

            ST_DUMP: begin
                // read address holds on r_cur while the output stalls
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = STAT_OK;
                    n_out_el     = w_rval;
                    n_out_ev     = 1'b1;
                    n_out_last   = (r_steps == '0);
                    n_out_len    = LEN_W'(r_count);
                    if (r_steps != '0) begin
                        n_cur   = w_rlink;
                        n_steps = r_steps - IW'(1);
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end

            ST_RESP: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_el     = '0;
                    n_out_ev     = 1'b0;
                    n_out_last   = 1'b1;
                    n_out_len    = LEN_W'(r_count);
                    n_state      = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // working and payload registers need no reset
    always_ff @(posedge i_clk) begin
        r_wop        <= n_wop;
        r_status     <= n_status;
        r_cur        <= n_cur;
        r_steps      <= n_steps;
        r_prev       <= n_prev;
        r_slot       <= n_slot;
        r_link       <= n_link;
        r_value      <= n_value;
        r_pval       <= n_pval;
        r_out_status <= n_out_status;
        r_out_el     <= n_out_el;
        r_out_ev     <= n_out_ev;
        r_out_last   <= n_out_last;
        r_out_len    <= n_out_len;
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_out_status;
    assign o_element       = r_out_el;
    assign o_element_valid = r_out_ev;
    assign o_last          = r_out_last;
    assign o_length        = r_out_len;

`ifndef SYNTH
    // a walk only ever runs over a non-empty list
    a_walk_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_count != '0))
        else $error("link walk on an empty list");

    // a full report only comes with a full list
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESP && r_status == STAT_FULL) |-> (r_count == CW'(CAPACITY)))
        else $error("full status with free slots");

    // the final dump item returns the sequencer to idle
    a_dump_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DUMP && w_out_free && r_steps == '0)
        |=> (r_state == ST_IDLE && o_valid && o_last))
        else $error("dump did not close with a last item");
`endif

endmodule
